@@ rtl/mersenne_twister_generator_macros.svh @@
// ----------------------------------------------------------------------------
// Mersenne twister generator assertion macros
// Shared concurrent assertion shorthands for the generator RTL.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_MACROS_SVH

// Checked on every rising edge of clk_i while rst_ni is high.
`define MTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define MTG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/mtg_pkg.sv @@
// ----------------------------------------------------------------------------
// Mersenne twister generator package
// Constants and word functions of the MT19937 recurrence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtg_pkg;

  localparam int unsigned StateWords = 624;
  localparam int unsigned ShiftTap   = 397;
  localparam int unsigned WordW      = 32;
  localparam int unsigned CntW       = $clog2(StateWords);
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  localparam logic [WordW-1:0] InitMult = 32'h6c07_8965;
  localparam logic [WordW-1:0] Matrix   = 32'h9908_b0df;
  localparam logic [WordW-1:0] UpperBit = 32'h8000_0000;
  localparam logic [WordW-1:0] LowerBit = 32'h7fff_ffff;
  localparam logic [WordW-1:0] TemperB  = 32'h9d2c_5680;
  localparam logic [WordW-1:0] TemperC  = 32'hefc6_0000;

  // Register index of the seed word.
  localparam logic [ApbAddrW-3:0] RegSeed = '0;

  localparam logic [WordW-1:0] SeedReset = 32'd5489;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t twist_word(word_t head, word_t next, word_t tap);
    word_t mix;
    word_t nv;
    mix = (head & UpperBit) | (next & LowerBit);
    nv  = tap ^ (mix >> 1);
    if (mix[0]) begin
      nv = nv ^ Matrix;
    end
    return nv;
  endfunction

  function automatic word_t temper(word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ rtl/mtg_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request beat with the reseed flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mtg_req_if;
  logic valid;
  logic ready;
  logic reseed;

  modport source (output valid, output reseed, input ready);
  modport sink (input valid, input reseed, output ready);
endinterface

@@ rtl/mtg_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one tempered random word per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mtg_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

@@ rtl/mersenne_twister_generator.sv @@
// ----------------------------------------------------------------------------
// MT19937 random word generator
// Without reseed a request is answered the cycle after it is accepted and one
// word per cycle is sustained while rsp_o is ready; the 624-cell chain shifts
// one word per beat. A reseed request, or the first one after reset, refills
// the chain from the seed register, one word a cycle through the multiplier,
// and answers once full. Reset clears control and sets the seed to 5489.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mersenne_twister_generator_macros.svh"

module mersenne_twister_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mtg_req_if.sink                         req_i,
  mtg_rsp_if.source                       rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mtg_pkg::ApbAddrW-1:0]    paddr,
  input  logic [mtg_pkg::ApbDataW-1:0]    pwdata,
  output logic [mtg_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);
  import mtg_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSeed = 2'd1;
  localparam logic [1:0] StGen  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            seeded_q, seeded_d;
  word_t           seed_q, seed_d;
  logic            out_valid_q, out_valid_d;
  word_t           out_word_q, out_word_d;

  word_t chain [StateWords];
  word_t tail_word;
  word_t step_word;
  word_t step_tempered;
  word_t seed_mix;
  word_t seed_prod;
  logic  shift;
  logic  req_beat;
  logic  cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[ApbAddrW-1:2] == RegSeed) ? seed_q : '0;
  assign seed_d    = (cfg_write && paddr[ApbAddrW-1:2] == RegSeed) ? pwdata : seed_q;

  assign req_i.ready = (state_q == StIdle) && (!out_valid_q || rsp_o.ready);
  assign req_beat    = req_i.valid && req_i.ready;

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.random_word = out_word_q;

  mtg_twist u_twist (
    .head_i     (chain[0]),
    .next_i     (chain[1]),
    .tap_i      (chain[ShiftTap]),
    .word_o     (step_word),
    .tempered_o (step_tempered)
  );

  assign seed_mix  = chain[StateWords-1] ^ (chain[StateWords-1] >> 30);
  assign seed_prod = InitMult * seed_mix;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    seeded_d    = seeded_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_word_d  = out_word_q;
    shift       = 1'b0;
    tail_word   = step_word;
    case (state_q)
      StIdle: begin
        if (req_beat) begin
          if (req_i.reseed || !seeded_q) begin
            state_d = StSeed;
            cnt_d   = '0;
          end else begin
            shift       = 1'b1;
            out_valid_d = 1'b1;
            out_word_d  = step_tempered;
          end
        end
      end
      StSeed: begin
        shift     = 1'b1;
        tail_word = (cnt_q == '0) ? seed_q : seed_prod + word_t'(cnt_q);
        if (cnt_q == CntW'(StateWords - 1)) begin
          state_d  = StGen;
          seeded_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StGen: begin
        shift       = 1'b1;
        out_valid_d = 1'b1;
        out_word_d  = step_tempered;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  for (genvar i = 0; i < StateWords; i++) begin : g_chain
    if (i == StateWords - 1) begin : g_tail
      mtg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .word_i  (tail_word),
        .word_o  (chain[i])
      );
    end else begin : g_body
      mtg_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .word_i  (chain[i+1]),
        .word_o  (chain[i])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      seeded_q    <= 1'b0;
      seed_q      <= SeedReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      seeded_q    <= seeded_d;
      seed_q      <= seed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  `MTG_ASSERT(a_beat_progress, req_beat |=> (state_q == StSeed) || out_valid_q,
              "accepted request neither seeding nor answered")
  `MTG_ASSERT(a_seed_no_output, (state_q == StSeed) |-> !out_valid_q,
              "response pending while the chain is being seeded")
  `MTG_ASSERT(a_ready_idle, req_i.ready |-> (state_q == StIdle),
              "request ready outside idle")
  `MTG_ASSERT(a_gen_seeded, (state_q == StGen) |-> seeded_q && !out_valid_q,
              "seed step ended without a seeded, empty output stage")
  `MTG_ASSERT(a_cnt_range, cnt_q <= CntW'(StateWords - 1),
              "seed counter beyond the chain length")

endmodule

@@ rtl/mtg_cell.sv @@
// ----------------------------------------------------------------------------
// Mersenne twister state cell
// Holds one state word and takes its neighbor's word on every shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtg_cell (
  input  logic                          clk_i,
  input  logic                          shift_i,
  input  logic [mtg_pkg::WordW-1:0]     word_i,
  output logic [mtg_pkg::WordW-1:0]     word_o
);
  import mtg_pkg::*;

  word_t word_q;
  word_t word_d;

  assign word_d = shift_i ? word_i : word_q;

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

@@ rtl/mtg_twist.sv @@
// ----------------------------------------------------------------------------
// Mersenne twister step unit
// Forms the next state word from the chain head taps and tempers it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtg_twist (
  input  logic [mtg_pkg::WordW-1:0] head_i,
  input  logic [mtg_pkg::WordW-1:0] next_i,
  input  logic [mtg_pkg::WordW-1:0] tap_i,
  output logic [mtg_pkg::WordW-1:0] word_o,
  output logic [mtg_pkg::WordW-1:0] tempered_o
);
  import mtg_pkg::*;

  word_t nv;

  assign nv         = twist_word(head_i, next_i, tap_i);
  assign word_o     = nv;
  assign tempered_o = temper(nv);

endmodule
